### src/spa_pkg.sv
// Package for the sparse polynomial add unit: widths, function codes,
// controller state type and the command/status structs between the modules.
// Depends on nothing.
`default_nettype none

package spa_pkg;

   localparam int TERMS_MAX_DEF = 32;
   localparam int FUNC_W = 2;
   localparam int COEF_W = 32;
   localparam int EXP_W = 16;
   localparam int TERM_W = COEF_W + EXP_W;

   localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd2;

   localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_STEP,
      ST_FINISH
   } fsm_state_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic start;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic more;
      logic emits;
      logic push_ok;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

### src/spa_req_if.sv
// Request channel interface of the sparse polynomial add unit.
// Depends on spa_pkg for the payload widths.
`default_nettype none

interface spa_req_if;
   logic                              valid;
   logic                              ready;
   logic [spa_pkg::FUNC_W-1:0]        func;
   logic signed [spa_pkg::COEF_W-1:0] term_coefficient;
   logic [spa_pkg::EXP_W-1:0]         term_exponent;

   modport source (output valid, output func, output term_coefficient,
                   output term_exponent, input ready);
   modport sink (input valid, input func, input term_coefficient,
                 input term_exponent, output ready);
endinterface

`default_nettype wire

### src/spa_rsp_if.sv
// Response channel interface of the sparse polynomial add unit.
// Depends on spa_pkg for the payload widths.
`default_nettype none

interface spa_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [spa_pkg::COEF_W-1:0] result_coefficient;
   logic [spa_pkg::EXP_W-1:0]         result_exponent;
   logic                              last_term;
   logic                              empty_result;
   logic                              overflow;

   modport source (output valid, output result_coefficient, output result_exponent,
                   output last_term, output empty_result, output overflow,
                   input ready);
   modport sink (input valid, input result_coefficient, input result_exponent,
                 input last_term, input empty_result, input overflow,
                 output ready);
endinterface

`default_nettype wire

### src/spa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module spa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### src/spa_ctrl.sv
// Controller state machine of the sparse polynomial add unit.
// Depends on spa_pkg for the state type and the command/status structs.
`default_nettype none

module spa_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [spa_pkg::FUNC_W-1:0] req_func,
   output logic                            req_ready,
   input  wire spa_pkg::status_type        status,
   output spa_pkg::cmd_type                cmd
);

   spa_pkg::fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         spa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_func)
                  spa_pkg::FUNC_LOAD_A: cmd.load_a = 1'b1;
                  spa_pkg::FUNC_LOAD_B: cmd.load_b = 1'b1;
                  spa_pkg::FUNC_ADD: begin
                     cmd.start = 1'b1;
                     state_in  = spa_pkg::ST_FETCH;
                  end
                  default: ;
               endcase
            end
         end
         // The term stores have a registered read port; this state waits for the heads.
         spa_pkg::ST_FETCH: state_in = spa_pkg::ST_STEP;
         spa_pkg::ST_STEP: begin
            if (!status.more) begin
               state_in = spa_pkg::ST_FINISH;
            end else if (!status.emits || status.push_ok) begin
               cmd.step = 1'b1;
               state_in = spa_pkg::ST_FETCH;
            end
         end
         spa_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = spa_pkg::ST_IDLE;
            end
         end
         default: state_in = spa_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

### src/spa_datapath.sv
// Datapath of the sparse polynomial add unit: term stores, counts, merge
// compare and saturating add, held-back term and response register.
// Depends on spa_pkg and spa_ram.
`default_nettype none

module spa_datapath #(
   parameter int TERMS_MAX = spa_pkg::TERMS_MAX_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire spa_pkg::cmd_type                  cmd,
   output spa_pkg::status_type                    status,
   input  wire logic signed [spa_pkg::COEF_W-1:0] req_coef,
   input  wire logic [spa_pkg::EXP_W-1:0]         req_exp,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   output logic signed [spa_pkg::COEF_W-1:0]      rsp_coef,
   output logic [spa_pkg::EXP_W-1:0]              rsp_exp,
   output logic                                   rsp_last,
   output logic                                   rsp_empty,
   output logic                                   rsp_ovf
);

   localparam int IDX_W = (TERMS_MAX > 1) ? $clog2(TERMS_MAX) : 1;
   localparam int CNT_W = $clog2(TERMS_MAX + 1);
   localparam int CW = spa_pkg::COEF_W;
   localparam int EW = spa_pkg::EXP_W;

   logic [CNT_W-1:0] a_cnt_ff, a_cnt_in, b_cnt_ff, b_cnt_in;
   logic [CNT_W-1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic             dropped_ff, dropped_in;
   logic             ovf_ff, ovf_in;
   logic             a_full, b_full;

   logic [spa_pkg::TERM_W-1:0] a_rd, b_rd;
   logic [CW-1:0] a_coef, b_coef;
   logic [EW-1:0] a_exp, b_exp;

   logic          a_left, b_left, take_a, take_b, take_both;
   logic [CW:0]   sum_wide;
   logic          sat;
   logic [CW-1:0] sum_val, cand_coef;
   logic [EW-1:0] cand_exp;
   logic          cand_ovf, emits, out_free, push_ok;

   logic          pend_valid_ff, pend_valid_in;
   logic [CW-1:0] pend_coef_ff, pend_coef_in;
   logic [EW-1:0] pend_exp_ff, pend_exp_in;
   logic          pend_ovf_ff, pend_ovf_in;

   logic          out_valid_ff, out_valid_in;
   logic [CW-1:0] out_coef_ff, out_coef_in;
   logic [EW-1:0] out_exp_ff, out_exp_in;
   logic          out_last_ff, out_last_in;
   logic          out_empty_ff, out_empty_in;
   logic          out_ovf_ff, out_ovf_in;

   assign a_full = (a_cnt_ff == CNT_W'(TERMS_MAX));
   assign b_full = (b_cnt_ff == CNT_W'(TERMS_MAX));

   spa_ram #(.WIDTH(spa_pkg::TERM_W), .DEPTH(TERMS_MAX)) u_store_a (
      .clock      (clock),
      .wr_en      (cmd.load_a && !a_full),
      .wr_addr    (a_cnt_ff[IDX_W-1:0]),
      .wr_data    ({req_coef, req_exp}),
      .rd_addr    (ia_ff[IDX_W-1:0]),
      .rd_data_ff (a_rd)
   );

   spa_ram #(.WIDTH(spa_pkg::TERM_W), .DEPTH(TERMS_MAX)) u_store_b (
      .clock      (clock),
      .wr_en      (cmd.load_b && !b_full),
      .wr_addr    (b_cnt_ff[IDX_W-1:0]),
      .wr_data    ({req_coef, req_exp}),
      .rd_addr    (ib_ff[IDX_W-1:0]),
      .rd_data_ff (b_rd)
   );

   assign a_coef = a_rd[spa_pkg::TERM_W-1:EW];
   assign a_exp  = a_rd[EW-1:0];
   assign b_coef = b_rd[spa_pkg::TERM_W-1:EW];
   assign b_exp  = b_rd[EW-1:0];

   // Merge decision on the two store heads.
   always_comb begin
      a_left    = (ia_ff < a_cnt_ff);
      b_left    = (ib_ff < b_cnt_ff);
      take_both = a_left && b_left && (a_exp == b_exp);
      take_a    = a_left && (!b_left || (a_exp > b_exp));
      take_b    = b_left && (!a_left || (b_exp > a_exp));
      sum_wide  = {a_coef[CW-1], a_coef} + {b_coef[CW-1], b_coef};
      sat       = sum_wide[CW] ^ sum_wide[CW-1];
      if (sat) begin
         sum_val = sum_wide[CW] ? spa_pkg::COEF_MIN : spa_pkg::COEF_MAX;
      end else begin
         sum_val = sum_wide[CW-1:0];
      end
      if (take_both) begin
         cand_coef = sum_val;
      end else if (take_a) begin
         cand_coef = a_coef;
      end else begin
         cand_coef = b_coef;
      end
      cand_exp = (take_a || take_both) ? a_exp : b_exp;
      cand_ovf = ovf_ff | (take_both & sat);
      emits    = !(take_both && (sum_wide == '0));
      out_free = !out_valid_ff || rsp_ready;
      push_ok  = !pend_valid_ff || out_free;
   end

   assign status = '{more: a_left || b_left, emits: emits, push_ok: push_ok,
                     out_free: out_free};

   always_comb begin
      a_cnt_in      = a_cnt_ff;
      b_cnt_in      = b_cnt_ff;
      dropped_in    = dropped_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      ovf_in        = ovf_ff;
      pend_valid_in = pend_valid_ff;
      pend_coef_in  = pend_coef_ff;
      pend_exp_in   = pend_exp_ff;
      pend_ovf_in   = pend_ovf_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_coef_in   = out_coef_ff;
      out_exp_in    = out_exp_ff;
      out_last_in   = out_last_ff;
      out_empty_in  = out_empty_ff;
      out_ovf_in    = out_ovf_ff;

      if (cmd.load_a) begin
         if (a_full) begin
            dropped_in = 1'b1;
         end else begin
            a_cnt_in = a_cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.load_b) begin
         if (b_full) begin
            dropped_in = 1'b1;
         end else begin
            b_cnt_in = b_cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.start) begin
         ia_in         = '0;
         ib_in         = '0;
         ovf_in        = dropped_ff;
         pend_valid_in = 1'b0;
      end
      if (cmd.step) begin
         ia_in  = ia_ff + CNT_W'(take_a || take_both);
         ib_in  = ib_ff + CNT_W'(take_b || take_both);
         ovf_in = cand_ovf;
         if (emits) begin
            // The held-back term is known not to be the last one now.
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_coef_in  = pend_coef_ff;
               out_exp_in   = pend_exp_ff;
               out_last_in  = 1'b0;
               out_empty_in = 1'b0;
               out_ovf_in   = pend_ovf_ff;
            end
            pend_valid_in = 1'b1;
            pend_coef_in  = cand_coef;
            pend_exp_in   = cand_exp;
            pend_ovf_in   = cand_ovf;
         end
      end
      if (cmd.finish) begin
         out_valid_in  = 1'b1;
         out_last_in   = 1'b1;
         out_empty_in  = !pend_valid_ff;
         out_coef_in   = pend_valid_ff ? pend_coef_ff : '0;
         out_exp_in    = pend_valid_ff ? pend_exp_ff : '0;
         out_ovf_in    = pend_valid_ff ? pend_ovf_ff : ovf_ff;
         pend_valid_in = 1'b0;
         a_cnt_in      = '0;
         b_cnt_in      = '0;
         ia_in         = '0;
         ib_in         = '0;
         dropped_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_cnt_ff      <= '0;
         b_cnt_ff      <= '0;
         dropped_ff    <= 1'b0;
         ia_ff         <= '0;
         ib_ff         <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         a_cnt_ff      <= a_cnt_in;
         b_cnt_ff      <= b_cnt_in;
         dropped_ff    <= dropped_in;
         ia_ff         <= ia_in;
         ib_ff         <= ib_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_coef_ff <= pend_coef_in;
      pend_exp_ff  <= pend_exp_in;
      pend_ovf_ff  <= pend_ovf_in;
      out_coef_ff  <= out_coef_in;
      out_exp_ff   <= out_exp_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_coef  = out_coef_ff;
   assign rsp_exp   = out_exp_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_empty = out_empty_ff;
   assign rsp_ovf   = out_ovf_ff;

   // Read indices never run past the stored term counts.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (ia_ff <= a_cnt_ff) && (ib_ff <= b_cnt_ff))
      else $error("merge index ran past store count");

   // A term is moved into the response register only when that register is free.
   push_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && emits && pend_valid_ff) || cmd.finish |-> out_free)
      else $error("response register overwritten");

   // An empty-sum transaction is always the last one and carries a zero term.
   empty_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_empty_ff |-> out_last_ff && (out_coef_ff == '0))
      else $error("malformed empty result");

   // Stores are emptied once the final transaction is queued.
   finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (a_cnt_ff == '0) && (b_cnt_ff == '0) && !pend_valid_ff)
      else $error("stores not cleared after add");

endmodule

`default_nettype wire

### src/sparse_polynomial_add_unit.sv
// A load transaction is taken in the idle state. An add transaction runs merge
// steps, each a fetch state for the registered read of the term stores followed
// by a step state for the compare and saturating add.
// Loads are accepted every cycle while idle; merge steps wait on a full output.
// Reset (synchronous, active high) empties both stores and clears the drop flag.
`default_nettype none

// Top level of the sparse polynomial add unit. Depends on spa_pkg, spa_req_if,
// spa_rsp_if, spa_ctrl and spa_datapath.
//
// Load transactions append a term to store A or store B; an add transaction
// merges both stores by falling exponent and streams the sum terms out. The
// datapath holds each new term back by one step so that the final one can be
// marked with last_term once the merge is known to be done, even when later
// terms cancel to zero. When nothing survives, a single empty_result
// transaction is sent. Requests are taken only while no add is in progress;
// the final response may still be waiting in the output register then.
module sparse_polynomial_add_unit #(
   parameter int TERMS_MAX = spa_pkg::TERMS_MAX_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   spa_req_if.sink   req_if,
   spa_rsp_if.source rsp_if
);

   spa_pkg::cmd_type    cmd;
   spa_pkg::status_type status;

   // Sequencer: decodes requests and paces the merge steps.
   spa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_func  (req_if.func),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Term stores, merge logic and the response register.
   spa_datapath #(.TERMS_MAX(TERMS_MAX)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_coef  (req_if.term_coefficient),
      .req_exp   (req_if.term_exponent),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_coef  (rsp_if.result_coefficient),
      .rsp_exp   (rsp_if.result_exponent),
      .rsp_last  (rsp_if.last_term),
      .rsp_empty (rsp_if.empty_result),
      .rsp_ovf   (rsp_if.overflow)
   );

endmodule

`default_nettype wire
